[sv/csrm_pkg.sv]
// Types, constants and decode helpers shared by the signature rule matcher.
// No dependencies; every other file imports this package.
`default_nettype none
package csrm_pkg;

   localparam int RULE_DEPTH = 16;
   localparam int IDX_W      = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
   localparam int CNT_W      = $clog2(RULE_DEPTH + 1);

   localparam logic [95:0] INTEL_VENDOR = 96'h6c65746e_49656e69_756e6547;
   localparam logic [95:0] AMD_VENDOR   = 96'h444d4163_69746e65_68747541;
   localparam logic [3:0]  EXT_FAMILY_CODE = 4'hf;

   typedef enum logic {
      OP_INSERT   = 1'b0,
      OP_CLASSIFY = 1'b1
   } op_type;

   typedef struct packed {
      op_type      operation;
      logic [31:0] vendor_word0;
      logic [31:0] vendor_word1;
      logic [31:0] vendor_word2;
      logic [31:0] signature_word;
      logic [8:0]  family_lo;
      logic [8:0]  family_hi;
      logic [7:0]  model_lo;
      logic [7:0]  model_hi;
      logic [3:0]  stepping_lo;
      logic [3:0]  stepping_hi;
   } req_payload_type;

   typedef struct packed {
      logic        matched;
      logic [3:0]  rule_index;
      logic [8:0]  decoded_family;
      logic [7:0]  decoded_model;
      logic [3:0]  decoded_stepping;
      logic        table_full;
   } rsp_payload_type;

   // one stored rule
   typedef struct packed {
      logic [95:0] vendor;
      logic [8:0]  family_lo;
      logic [8:0]  family_hi;
      logic [7:0]  model_lo;
      logic [7:0]  model_hi;
      logic [3:0]  stepping_lo;
      logic [3:0]  stepping_hi;
   } rule_type;

   // classify query walking the cell row
   typedef struct packed {
      logic             valid;
      logic [95:0]      vendor;
      logic [8:0]       family;
      logic [7:0]       model;
      logic [3:0]       stepping;
      logic             found;
      logic [IDX_W-1:0] index;
   } token_type;

endpackage
`default_nettype wire

[sv/csrm_if.sv]
// Request and response channel interfaces (valid/ready with payload).
// Depends on csrm_pkg.
`default_nettype none
interface csrm_req_if;
   import csrm_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface csrm_rsp_if;
   import csrm_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[sv/csrm_cell.sv]
// One rule slot of the matcher row: holds a rule and checks the passing query.
// Depends on csrm_pkg.
`default_nettype none
module csrm_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      wr_en,
   input  wire csrm_pkg::rule_type        wr_rule,
   input  wire logic                      live,
   input  wire logic [csrm_pkg::IDX_W-1:0] cell_index,
   input  wire csrm_pkg::token_type       tok_i,
   output csrm_pkg::token_type            tok_o
);
   import csrm_pkg::*;

   rule_type  rule_ff;
   token_type tok_ff;
   token_type tok_in;
   logic      hit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rule_ff <= wr_rule;
      end
   end

   always_comb begin
      hit = live
         && (rule_ff.vendor == tok_i.vendor)
         && (tok_i.family >= rule_ff.family_lo) && (tok_i.family <= rule_ff.family_hi)
         && (tok_i.model >= rule_ff.model_lo) && (tok_i.model <= rule_ff.model_hi)
         && (tok_i.stepping >= rule_ff.stepping_lo)
         && (tok_i.stepping <= rule_ff.stepping_hi);
      tok_in = tok_i;
      // first match wins: later cells leave a found token alone
      if (tok_i.valid && !tok_i.found && hit) begin
         tok_in.found = 1'b1;
         tok_in.index = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.vendor   <= tok_in.vendor;
      tok_ff.family   <= tok_in.family;
      tok_ff.model    <= tok_in.model;
      tok_ff.stepping <= tok_in.stepping;
      tok_ff.found    <= tok_in.found;
      tok_ff.index    <= tok_in.index;
   end

   assign tok_o = tok_ff;

endmodule
`default_nettype wire

[sv/cpu_signature_rule_matcher_core.sv]
// Insert: result registered the cycle after the transaction; another may follow each cycle
// unless a classify is busy or the response stalls. Classify: the query walks the row of
// RULE_DEPTH rule cells, one cell per cycle, waits in a pending register until the output
// stage is free, then moves to the response register; one classify at a time, so no other
// transaction is taken until then. Reset (synchronous) empties the rule count and drops any
// query in flight; rule storage is not cleared, as only slots below the count are compared.
`default_nettype none
module cpu_signature_rule_matcher_core (
   input  wire logic clock,
   input  wire logic reset,
   csrm_req_if.sink   req,
   csrm_rsp_if.source rsp
);
   import csrm_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_payload_type  pend_data_ff, pend_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic             out_free;
   logic             accept;
   logic             is_insert;
   logic             full;
   logic             pend_move;
   logic [95:0]      vendor;
   logic             ext_decode;
   logic [8:0]       family;
   logic [7:0]       model;
   rule_type         new_rule;
   rsp_payload_type  ins_rsp;
   rsp_payload_type  exit_rsp;
   token_type        tok [0:RULE_DEPTH];

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = !busy_ff && out_free;
   assign accept    = req.valid && req.ready;
   assign is_insert = (req.payload.operation == OP_INSERT);
   assign full      = (count_ff >= CNT_W'(RULE_DEPTH));
   assign pend_move = pend_valid_ff && out_free;

   assign vendor = {req.payload.vendor_word2, req.payload.vendor_word1,
                    req.payload.vendor_word0};

   // signature decode
   always_comb begin
      ext_decode = (vendor == INTEL_VENDOR)
         || ((vendor == AMD_VENDOR) && (req.payload.signature_word[11:8] == EXT_FAMILY_CODE));
      family = {5'd0, req.payload.signature_word[11:8]};
      model  = {4'd0, req.payload.signature_word[7:4]};
      if (ext_decode) begin
         family = family + {1'b0, req.payload.signature_word[27:20]};
         model  = {req.payload.signature_word[19:16], req.payload.signature_word[7:4]};
      end
   end

   always_comb begin
      new_rule.vendor      = vendor;
      new_rule.family_lo   = req.payload.family_lo;
      new_rule.family_hi   = req.payload.family_hi;
      new_rule.model_lo    = req.payload.model_lo;
      new_rule.model_hi    = req.payload.model_hi;
      new_rule.stepping_lo = req.payload.stepping_lo;
      new_rule.stepping_hi = req.payload.stepping_hi;

      ins_rsp                  = '0;
      ins_rsp.table_full       = full;
      ins_rsp.rule_index       = full ? 4'd0 : 4'(count_ff);

      tok[0].valid    = accept && !is_insert;
      tok[0].vendor   = vendor;
      tok[0].family   = family;
      tok[0].model    = model;
      tok[0].stepping = req.payload.signature_word[3:0];
      tok[0].found    = 1'b0;
      tok[0].index    = '0;
   end

   for (genvar i = 0; i < RULE_DEPTH; i++) begin : g_cell
      logic wr_en;
      logic live;
      assign wr_en = accept && is_insert && !full && (count_ff == CNT_W'(i));
      assign live  = (CNT_W'(i) < count_ff);
      csrm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (wr_en),
         .wr_rule    (new_rule),
         .live       (live),
         .cell_index (IDX_W'(i)),
         .tok_i      (tok[i]),
         .tok_o      (tok[i+1])
      );
   end

   always_comb begin
      exit_rsp                  = '0;
      exit_rsp.matched          = tok[RULE_DEPTH].found;
      exit_rsp.rule_index       = tok[RULE_DEPTH].found ? 4'(tok[RULE_DEPTH].index) : 4'd0;
      exit_rsp.decoded_family   = tok[RULE_DEPTH].family;
      exit_rsp.decoded_model    = tok[RULE_DEPTH].model;
      exit_rsp.decoded_stepping = tok[RULE_DEPTH].stepping;
   end

   always_comb begin
      count_in      = count_ff;
      busy_in       = busy_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (accept && is_insert && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (accept && !is_insert) begin
         busy_in = 1'b1;
      end
      // result leaving the row waits here until the output stage is free
      if (tok[RULE_DEPTH].valid) begin
         pend_valid_in = 1'b1;
         pend_data_in  = exit_rsp;
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && is_insert) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ins_rsp;
      end else if (pend_move) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = pend_data_ff;
         pend_valid_in = 1'b0;
         busy_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_data_ff <= pend_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

endmodule
`default_nettype wire
